/* rtl/pfe_pkg.sv */
`default_nettype none

package pfe_pkg;

  // square geometry and letter coding
  localparam int SQUARE_SIDE = 5;
  localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;
  localparam int OP_W        = 2;
  localparam int RC_W        = $clog2(SQUARE_SIDE);
  localparam int CELL_W      = $clog2(CELLS);
  localparam int FILL_W      = $clog2(CELLS + 1);

  localparam logic [LETTER_W-1:0] CODE_I      = 5'd8;
  localparam logic [LETTER_W-1:0] CODE_J      = 5'd9;
  localparam logic [LETTER_W-1:0] CODE_X      = 5'd23;
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_KEY     = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY_END = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;

  // cell of a letter in the square
  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  localparam int POS_W = $bits(pos_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_TEXT,
    ST_RD_POS,
    ST_RD_KEY,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic key_place;
    logic fill_step;
    logic text_decide;
    logic pos_rd;
    logic key_rd;
    logic out_load;
    logic pair_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_closed;
    logic            fill_last;
    logic [1:0]      pair_cnt;
    logic            more_pairs;
    logic            out_free;
  } status_t;

  // step one place along a row or column, wrapping
  function automatic logic [RC_W-1:0] wrap_inc(input logic [RC_W-1:0] v);
    return (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

  // linear cell number of a square position
  function automatic logic [CELL_W-1:0] cell_index(input pos_t p);
    return CELL_W'(p.row * SQUARE_SIDE) + CELL_W'(p.col);
  endfunction

endpackage

`default_nettype wire

/* rtl/pfe_if.sv */
`default_nettype none

// input letter channel
interface pfe_in_if;
  import pfe_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [LETTER_W-1:0] letter;
  logic                message_last;

  modport source (output valid, operation, letter, message_last, input ready);
  modport sink   (input valid, operation, letter, message_last, output ready);
endinterface

// digraph result channel
interface pfe_out_if;
  import pfe_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] first_cipher;
  logic [LETTER_W-1:0] second_cipher;
  logic                run_last;
  logic                message_end;

  modport source (output valid, first_cipher, second_cipher, run_last, message_end,
                  input ready);
  modport sink   (input valid, first_cipher, second_cipher, run_last, message_end,
                  output ready);
endinterface

`default_nettype wire

/* rtl/pfe_ram.sv */
`default_nettype none

module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

/* rtl/pfe_ctrl.sv */
`default_nettype none

module pfe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pfe_pkg::status_t st,
  output pfe_pkg::cmd_t         cmd
);
  import pfe_pkg::*;

  state_t state_r, state_nxt;

  // state register; reset starts with the square fill pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (st.op)
          OP_KEY: begin
            cmd.key_place = 1'b1;
            state_nxt     = ST_IDLE;
          end
          OP_KEY_END: state_nxt = st.key_closed ? ST_IDLE : ST_FILL;
          OP_TEXT:    state_nxt = st.key_closed ? ST_TEXT : ST_FILL;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          state_nxt = (st.op == OP_TEXT) ? ST_TEXT : ST_IDLE;
        end
      end
      ST_TEXT: begin
        cmd.text_decide = 1'b1;
        state_nxt       = (st.pair_cnt == 2'd0) ? ST_IDLE : ST_RD_POS;
      end
      ST_RD_POS: begin
        cmd.pos_rd = 1'b1;
        state_nxt  = ST_RD_KEY;
      end
      ST_RD_KEY: begin
        cmd.key_rd = 1'b1;
        state_nxt  = ST_SEND;
      end
      ST_SEND: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.more_pairs) begin
            cmd.pair_next = 1'b1;
            state_nxt     = ST_RD_POS;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pfe_datapath.sv */
`default_nettype none

module pfe_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [pfe_pkg::OP_W-1:0]       in_operation,
  input  wire logic [pfe_pkg::LETTER_W-1:0]   in_letter,
  input  wire logic                           in_message_last,
  input  wire pfe_pkg::cmd_t                  cmd,
  output pfe_pkg::status_t                    st,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic      [pfe_pkg::LETTER_W-1:0]   out_first_cipher,
  output logic      [pfe_pkg::LETTER_W-1:0]   out_second_cipher,
  output logic                                out_run_last,
  output logic                                out_message_end
);
  import pfe_pkg::*;

  // latched item
  logic [OP_W-1:0]     op_r;
  logic [LETTER_W-1:0] letter_r;
  logic                last_r;

  // key state
  logic [LETTERS-1:0]  used_r, used_nxt;
  logic [FILL_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  pos_t                fill_pos_r, fill_pos_nxt;
  logic                key_closed_r, key_closed_nxt;
  logic [LETTER_W-1:0] fill_j_r;

  // pending plaintext letter
  logic [LETTER_W-1:0] pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;

  // queued digraphs
  logic [LETTER_W-1:0] a0_r, b0_r, a1_r, b1_r;
  logic [1:0]          pair_cnt_r;
  logic                pair_idx_r;

  // output register
  logic                out_valid_r;
  logic [LETTER_W-1:0] out_first_r, out_second_r;
  logic                out_run_last_r, out_msg_end_r;

  // placement
  logic                clear_key;
  logic [LETTERS-1:0]  eff_used;
  logic [FILL_W-1:0]   eff_cnt;
  pos_t                eff_pos;
  logic [LETTER_W-1:0] cand;
  logic                place_en;

  // digraph decision
  logic                dec_letter_ok;
  logic [LETTER_W-1:0] dec_a0, dec_b0, dec_a1, dec_b1;
  logic [1:0]          dec_cnt;

  // lookups
  logic [LETTER_W-1:0] cur_a, cur_b;
  logic [POS_W-1:0]    pos_a_q, pos_b_q;
  pos_t                pa, pb, c1, c2;
  logic [LETTER_W-1:0] key_q1, key_q2;
  logic                out_free;

  // latch the accepted item, j folded into i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_KEY_END;
    end else if (cmd.load) begin
      op_r <= in_operation;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      letter_r <= (in_letter == CODE_J) ? CODE_I : in_letter;
      last_r   <= in_message_last;
    end
  end

  // key letter after key end starts from an empty square
  assign clear_key = cmd.key_place && key_closed_r;
  assign eff_used  = clear_key ? '0 : used_r;
  assign eff_cnt   = clear_key ? '0 : fill_cnt_r;
  assign eff_pos   = clear_key ? '0 : fill_pos_r;
  assign cand      = cmd.fill_step ? fill_j_r : letter_r;
  assign place_en  = (cmd.key_place || cmd.fill_step) && (cand <= LAST_LETTER) &&
                     (cand != CODE_J) && (eff_cnt != FILL_W'(CELLS)) && !eff_used[cand];

  // key state update
  always_comb begin
    used_nxt       = eff_used;
    fill_cnt_nxt   = eff_cnt;
    fill_pos_nxt   = eff_pos;
    key_closed_nxt = key_closed_r;
    if (place_en) begin
      used_nxt     = eff_used | (LETTERS'(1) << cand);
      fill_cnt_nxt = eff_cnt + 1'b1;
      if (eff_pos.col == RC_W'(SQUARE_SIDE - 1)) begin
        fill_pos_nxt.row = eff_pos.row + 1'b1;
        fill_pos_nxt.col = '0;
      end else begin
        fill_pos_nxt.col = eff_pos.col + 1'b1;
      end
    end
    if (clear_key) begin
      key_closed_nxt = 1'b0;
    end else if (cmd.fill_step && fill_j_r == LAST_LETTER) begin
      key_closed_nxt = 1'b1;
    end
  end

  // pairing of plaintext letters
  always_comb begin
    logic [LETTER_W-1:0] p_l;
    logic                p_v;
    p_l           = pend_r;
    p_v           = pend_vld_r;
    dec_a0        = pend_r;
    dec_b0        = CODE_X;
    dec_a1        = pend_r;
    dec_b1        = CODE_X;
    dec_cnt       = 2'd0;
    dec_letter_ok = (letter_r <= LAST_LETTER);
    if (dec_letter_ok) begin
      if (p_v) begin
        dec_a0  = p_l;
        dec_cnt = 2'd1;
        if (p_l == letter_r) begin
          dec_b0 = CODE_X;
        end else begin
          dec_b0 = letter_r;
          p_v    = 1'b0;
          p_l    = '0;
        end
      end else begin
        p_l = letter_r;
        p_v = 1'b1;
      end
    end
    if (last_r && p_v) begin
      if (dec_cnt == 2'd0) begin
        dec_a0 = p_l;
        dec_b0 = CODE_X;
      end else begin
        dec_a1 = p_l;
        dec_b1 = CODE_X;
      end
      dec_cnt = dec_cnt + 2'd1;
      p_v     = 1'b0;
      p_l     = '0;
    end
    pend_nxt     = p_l;
    pend_vld_nxt = p_v;
    if (clear_key) begin
      pend_nxt     = '0;
      pend_vld_nxt = 1'b0;
    end else if (!cmd.text_decide) begin
      pend_nxt     = pend_r;
      pend_vld_nxt = pend_vld_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      fill_cnt_r   <= '0;
      fill_pos_r   <= '0;
      key_closed_r <= 1'b1;
      fill_j_r     <= '0;
      pend_r       <= '0;
      pend_vld_r   <= 1'b0;
      pair_cnt_r   <= '0;
      pair_idx_r   <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      fill_pos_r   <= fill_pos_nxt;
      key_closed_r <= key_closed_nxt;
      pend_r       <= pend_nxt;
      pend_vld_r   <= pend_vld_nxt;
      if (cmd.fill_step) begin
        fill_j_r <= (fill_j_r == LAST_LETTER) ? '0 : fill_j_r + 1'b1;
      end
      if (cmd.text_decide) begin
        pair_cnt_r <= dec_cnt;
        pair_idx_r <= 1'b0;
      end else if (cmd.pair_next) begin
        pair_idx_r <= 1'b1;
      end
    end
  end

  // digraph letters
  always_ff @(posedge clk) begin
    if (cmd.text_decide) begin
      a0_r <= dec_a0;
      b0_r <= dec_b0;
      a1_r <= dec_a1;
      b1_r <= dec_b1;
    end
  end

  assign cur_a = pair_idx_r ? a1_r : a0_r;
  assign cur_b = pair_idx_r ? b1_r : b0_r;

  // letter to position table
  pfe_ram #(.WIDTH(POS_W), .DEPTH(LETTERS)) u_pos_ram (
    .clk    (clk),
    .we     (place_en),
    .waddr  (cand),
    .wdata  (eff_pos),
    .re     (cmd.pos_rd),
    .raddr0 (cur_a),
    .raddr1 (cur_b),
    .rdata0 (pos_a_q),
    .rdata1 (pos_b_q)
  );

  // same row, same column and rectangle rules
  always_comb begin
    pa = pos_t'(pos_a_q);
    pb = pos_t'(pos_b_q);
    if (pa.row == pb.row) begin
      c1 = '{row: pa.row, col: wrap_inc(pa.col)};
      c2 = '{row: pb.row, col: wrap_inc(pb.col)};
    end else if (pa.col == pb.col) begin
      c1 = '{row: wrap_inc(pa.row), col: pa.col};
      c2 = '{row: wrap_inc(pb.row), col: pb.col};
    end else begin
      c1 = '{row: pa.row, col: pb.col};
      c2 = '{row: pb.row, col: pa.col};
    end
  end

  // key square
  pfe_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_key_ram (
    .clk    (clk),
    .we     (place_en),
    .waddr  (cell_index(eff_pos)),
    .wdata  (cand),
    .re     (cmd.key_rd),
    .raddr0 (cell_index(c1)),
    .raddr1 (cell_index(c2)),
    .rdata0 (key_q1),
    .rdata1 (key_q2)
  );

  // result register, freed by a transfer
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_first_r    <= key_q1;
      out_second_r   <= key_q2;
      out_run_last_r <= !st.more_pairs;
      out_msg_end_r  <= last_r && !st.more_pairs;
    end
  end

  // status
  always_comb begin
    st            = '0;
    st.op         = op_r;
    st.key_closed = key_closed_r;
    st.fill_last  = (fill_j_r == LAST_LETTER);
    st.pair_cnt   = dec_cnt;
    st.more_pairs = !pair_idx_r && (pair_cnt_r == 2'd2);
    st.out_free   = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_first_cipher  = out_first_r;
  assign out_second_cipher = out_second_r;
  assign out_run_last      = out_run_last_r;
  assign out_message_end   = out_msg_end_r;

endmodule

`default_nettype wire

/* rtl/playfair_encrypt_stream.sv */
// Playfair encryption over a 5x5 key square, one item at a time.
// in_ch carries items: operation (key letter, end of key, plaintext letter),
// letter (A=0..Z=25, J folded into I) and message_last. out_ch carries one
// enciphered digraph per transfer, with run_last on the last digraph of an
// item and message_end on the final digraph of a message.
// Steps, from the input transfer:
//   key letter: placed in the square, no result
//   end of key with an open key: a 26-letter fill walk, one a cycle
//   plaintext letter: paired with any pending letter; each digraph is read from
//   the position memory, then the key square, and registered; an open key
//   adds the fill walk first.
// The rate is set by the two lookups per digraph: letter position memory,
// then key square memory, each with a registered read.
// Reset: the square is loaded with the plain alphabet by a 26-letter pass;
// in_ch.ready stays low until it ends.
// A stalled receiver holds the digraph in the output register; the next
// item is still taken, and its first digraph waits until the register frees.
`default_nettype none

module playfair_encrypt_stream (
  input  wire logic clk,
  input  wire logic rst_n,
  pfe_in_if.sink    in_ch,
  pfe_out_if.source out_ch
);
  import pfe_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // key square, pairing and lookups
  pfe_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_ch.operation),
    .in_letter         (in_ch.letter),
    .in_message_last   (in_ch.message_last),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_first_cipher  (out_ch.first_cipher),
    .out_second_cipher (out_ch.second_cipher),
    .out_run_last      (out_ch.run_last),
    .out_message_end   (out_ch.message_end)
  );

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while busy");

  // message end only on an item's last digraph
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.message_end) |-> out_ch.run_last)
    else $error("message end before last digraph");

  // a second digraph follows only a load of the first
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_next |-> cmd.out_load)
    else $error("pair advanced without a result");

endmodule

`default_nettype wire
